[rtl/jpeg_frame_size_parser_defines.svh]
// Assertion macros shared by the frame size parser RTL.
`ifndef JPEG_FRAME_SIZE_PARSER_DEFINES_SVH
`define JPEG_FRAME_SIZE_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held.
`define JFSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is held.
`define JFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JFSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define JFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/jfsp_pkg.sv]
// Types, codes and constant tables of the frame size parser.
package jfsp_pkg;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_MARKER = 3'd2;
  localparam logic [2:0] PH_LENGTH = 3'd3;
  localparam logic [2:0] PH_FRAME  = 3'd4;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_BAD_START = 3'd1;
  localparam logic [2:0] ST_NO_JFIF   = 3'd2;
  localparam logic [2:0] ST_CORRUPT   = 3'd3;
  localparam logic [2:0] ST_EARLY     = 3'd4;

  localparam logic [7:0] MARKER_PREFIX = 8'hFF;
  localparam logic [7:0] MARKER_SOI    = 8'hD8;
  localparam logic [7:0] MARKER_APP0   = 8'hE0;
  localparam logic [7:0] MARKER_SOF0   = 8'hC0;

  typedef struct packed {
    logic [2:0]  phase;
    logic [3:0]  pos;
    logic [16:0] skip;
    logic [7:0]  len_hi;
    logic [15:0] height;
    logic [7:0]  width_hi;
    logic        decided;
  } jfsp_state_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  status;
    logic [15:0] height;
    logic [15:0] width;
  } jfsp_result_t;

  function automatic logic [7:0] start_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = MARKER_PREFIX;
      2'd1:    val = MARKER_SOI;
      2'd2:    val = MARKER_PREFIX;
      default: val = MARKER_APP0;
    endcase
    return val;
  endfunction

  // The JFIF signature, zero terminated.
  function automatic logic [7:0] jfif_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h4A;
      3'd1:    val = 8'h46;
      3'd2:    val = 8'h49;
      3'd3:    val = 8'h46;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

[rtl/jfsp_intf.sv]
// Handshake channel interfaces for the byte input and the result output.
interface jfsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface jfsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] image_height;
  logic [15:0] image_width;

  modport source (output valid, output status, output image_height,
                  output image_width, input ready);
  modport sink   (input valid, input status, input image_height,
                  input image_width, output ready);
endinterface

[rtl/jpeg_frame_size_parser.sv]
// Throughput: one byte per cycle, sustained, whenever the result side is not stalling.
// The per-byte parse step sits between a one-entry input register and the result register.
// Each file gives exactly one result; its last byte returns the parser to the start state.
// Reset (rst_n low, synchronous) empties both registers and clears the parser state.
`include "jpeg_frame_size_parser_defines.svh"

module jpeg_frame_size_parser
  import jfsp_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  jfsp_in_if.sink        in_ch,
  jfsp_out_if.source     out_ch
);

  // Input register: holds one accepted byte request until the parse step takes it.
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;

  // Parser state, advanced once per processed byte.
  jfsp_state_t state_r;
  jfsp_state_t state_nxt;
  jfsp_result_t step_res;

  // Result register.
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [15:0] out_height_r;
  logic [15:0] out_width_r;

  logic        advance;
  logic        proc_fire;

  // The result register can take a new value when it is empty or being emptied.
  // The byte in the input register is processed exactly then, so the input
  // side keeps flowing while the result side keeps up, and a waiting result
  // still lets one further byte request be taken into the input register.
  assign advance   = !out_valid_r || out_ch.ready;
  assign proc_fire = in_valid_r && advance;
  assign in_ch.ready = !in_valid_r || advance;

  jfsp_step u_step (
    .st_cur  (state_r),
    .byte_in (in_byte_r),
    .last_in (in_last_r),
    .st_nxt  (state_nxt),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.data_byte;
      in_last_r <= in_ch.last_byte;
    end
  end

  // The header phase is coded as zero, so clearing the whole state selects it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (proc_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= proc_fire && step_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && step_res.valid) begin
      out_status_r <= step_res.status;
      out_height_r <= step_res.height;
      out_width_r  <= step_res.width;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.image_height = out_height_r;
  assign out_ch.image_width  = out_width_r;

  // Only a found frame carries dimensions.
  `JFSP_ASSERT_IMP(a_dims_zero, clk, rst_n,
                   out_valid_r && out_status_r != ST_FOUND,
                   out_height_r == 16'd0 && out_width_r == 16'd0,
                   "dimensions on a failed result")
  // Status codes stay within the defined set.
  `JFSP_ASSERT_IMP(a_status_range, clk, rst_n, out_valid_r, out_status_r <= ST_EARLY,
                   "status out of range")
  // The parser never reaches an undefined phase.
  `JFSP_ASSERT_IMP(a_phase_range, clk, rst_n, 1'b1, state_r.phase <= PH_FRAME,
                   "phase out of range")
  // The skip phase is only entered with bytes still to skip.
  `JFSP_ASSERT_IMP(a_skip_live, clk, rst_n, state_r.phase == PH_SKIP,
                   state_r.skip != 17'd0, "empty skip phase")
  // The final byte of a file leaves the parser ready for the next file.
  `JFSP_ASSERT_NEXT(a_last_clears, clk, rst_n, proc_fire && in_last_r,
                    state_r.phase == PH_HEADER && !state_r.decided && state_r.pos == 4'd0,
                    "parser not cleared after last byte")

endmodule

[rtl/jfsp_step.sv]
// Per-byte parse step: next parser state and the result the byte decides.
module jfsp_step
  import jfsp_pkg::*;
(
  input  jfsp_state_t  st_cur,
  input  logic [7:0]   byte_in,
  input  logic         last_in,
  output jfsp_state_t  st_nxt,
  output jfsp_result_t res
);

  always_comb begin
    jfsp_state_t  s;
    logic         hit;
    logic [2:0]   code;
    logic [15:0]  wid;
    logic [15:0]  seg_len;
    logic [16:0]  jump;
    logic         jump_en;
    logic [3:0]   sig_off;

    s       = st_cur;
    hit     = 1'b0;
    code    = ST_CORRUPT;
    wid     = 16'd0;
    seg_len = {st_cur.len_hi, byte_in};
    jump    = 17'd0;
    jump_en = 1'b0;
    sig_off = st_cur.pos - 4'd6;

    if (!st_cur.decided) begin
      case (st_cur.phase)
        PH_HEADER: begin
          if (st_cur.pos < 4'd4) begin
            if (byte_in != start_byte(st_cur.pos[1:0])) begin
              hit  = 1'b1;
              code = ST_BAD_START;
            end else begin
              s.pos = st_cur.pos + 4'd1;
            end
          end else if (st_cur.pos == 4'd4) begin
            s.len_hi = byte_in;
            s.pos    = st_cur.pos + 4'd1;
          end else if (st_cur.pos == 4'd5) begin
            s.skip = {1'b0, st_cur.len_hi, byte_in};
            s.pos  = st_cur.pos + 4'd1;
          end else if (st_cur.pos > 4'd10 || byte_in != jfif_byte(sig_off[2:0])) begin
            hit  = 1'b1;
            code = ST_NO_JFIF;
          end else if (st_cur.pos == 4'd10) begin
            if (st_cur.skip < 17'd7) begin
              hit  = 1'b1;
              code = ST_CORRUPT;
            end else begin
              jump    = st_cur.skip - 17'd7;
              jump_en = 1'b1;
            end
          end else begin
            s.pos = st_cur.pos + 4'd1;
          end
        end
        PH_SKIP: begin
          if (st_cur.skip != 17'd0) begin
            s.skip = st_cur.skip - 17'd1;
          end
          if (s.skip == 17'd0) begin
            s.phase = PH_MARKER;
            s.pos   = 4'd0;
          end
        end
        PH_MARKER: begin
          if (st_cur.pos == 4'd0) begin
            if (byte_in != MARKER_PREFIX) begin
              hit  = 1'b1;
              code = ST_CORRUPT;
            end else begin
              s.pos = 4'd1;
            end
          end else begin
            s.phase = (byte_in == MARKER_SOF0) ? PH_FRAME : PH_LENGTH;
            s.pos   = 4'd0;
          end
        end
        PH_LENGTH: begin
          if (st_cur.pos == 4'd0) begin
            s.len_hi = byte_in;
            s.pos    = 4'd1;
          end else if (seg_len < 16'd2) begin
            hit  = 1'b1;
            code = ST_CORRUPT;
          end else begin
            jump    = {1'b0, seg_len - 16'd2};
            jump_en = 1'b1;
          end
        end
        PH_FRAME: begin
          if (st_cur.pos >= 4'd6) begin
            hit  = 1'b1;
            code = ST_FOUND;
            wid  = {st_cur.width_hi, byte_in};
          end else begin
            if (st_cur.pos == 4'd3) begin
              s.height = {byte_in, 8'h00};
            end else if (st_cur.pos == 4'd4) begin
              s.height = {st_cur.height[15:8], byte_in};
            end else if (st_cur.pos == 4'd5) begin
              s.width_hi = byte_in;
            end
            s.pos = st_cur.pos + 4'd1;
          end
        end
        default: begin
          hit  = 1'b1;
          code = ST_CORRUPT;
        end
      endcase
    end

    // Jump over a segment body, or straight to the next marker if it is empty.
    if (jump_en) begin
      s.skip  = jump;
      s.pos   = 4'd0;
      s.phase = (jump == 17'd0) ? PH_MARKER : PH_SKIP;
    end

    res.valid  = 1'b0;
    res.status = code;
    res.height = 16'd0;
    res.width  = 16'd0;
    if (hit) begin
      res.valid = 1'b1;
      s.decided = 1'b1;
      if (code == ST_FOUND) begin
        res.height = s.height;
        res.width  = wid;
      end
    end else if (last_in && !st_cur.decided) begin
      res.valid  = 1'b1;
      res.status = ST_EARLY;
    end

    // The final byte of a file always returns the parser to its reset state.
    if (last_in) begin
      s = '0;
      s.phase = PH_HEADER;
    end

    st_nxt = s;
  end

endmodule

[sim/tb_jpeg_frame_size_parser.sv]
// Self-checking JPEG frame size parser testbench: directed and random streams, predicted reports.
module tb_jpeg_frame_size_parser;
  import jfsp_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] height;
    logic [15:0] width;
  } frame_result_t;

  // One row of the directed table. Where typed is set, the report is written out by hand
  // and replaces the predicted one.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    bit          typed;
    logic [2:0]  status;
    logic [15:0] height;
    logic [15:0] width;
  } stim_row_t;

  typedef enum int {
    FILE_GOOD, FILE_SHORT_APP0, FILE_SHORT_SEG, FILE_NO_MARKER,
    FILE_FLIPPED, FILE_NOISE, FILE_HUGE
  } file_kind_e;

  localparam int          DIRECTED_ROWS = 25;
  localparam int          RANDOM_BYTES  = 1900;
  localparam logic [31:0] START_SEQ = {MARKER_PREFIX, MARKER_SOI, MARKER_PREFIX, MARKER_APP0};
  localparam logic [39:0] JFIF_SIG  = 40'h4A_46_49_46_00;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  jfsp_in_if  byte_ch ();
  jfsp_out_if size_ch ();

  jpeg_frame_size_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (byte_ch),
    .out_ch (size_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state, held at its reset values from the start.
  logic [2:0]  jp_phase    = PH_HEADER;
  logic [3:0]  jp_pos      = '0;
  logic [16:0] jp_skip     = '0;
  logic [7:0]  jp_len_hi   = '0;
  logic [15:0] jp_height   = '0;
  logic [7:0]  jp_width_hi = '0;
  logic        jp_done     = 1'b0;

  frame_result_t pending_reports [$];
  logic [7:0]    file_buf [$];
  stim_row_t     directed_tbl [DIRECTED_ROWS];
  bit            cur_typed;
  frame_result_t cur_want;
  int            mismatches   = 0;
  int            reports_seen = 0;

  function automatic void begin_skip(input logic [16:0] count);
    jp_skip  = count;
    jp_pos   = '0;
    jp_phase = (count == 17'd0) ? PH_MARKER : PH_SKIP;
  endfunction

  // Steps the predictor by one byte; returns 1 when the byte causes a report.
  function automatic bit parse_jpeg_byte(input logic [7:0] b, input logic last,
                                         output frame_result_t r);
    bit          decides;
    logic [2:0]  verdict;
    logic [15:0] seg_len;
    logic [15:0] w;
    bit          has;
    decides = 1'b0;
    verdict = ST_CORRUPT;
    w       = '0;
    has     = 1'b0;
    r       = '0;
    if (!jp_done) begin
      case (jp_phase)
        PH_HEADER: begin
          if (jp_pos < 4'd4) begin
            if (b != START_SEQ[31 - 8*jp_pos -: 8]) begin
              decides = 1'b1;
              verdict = ST_BAD_START;
            end else begin
              jp_pos = jp_pos + 4'd1;
            end
          end else if (jp_pos == 4'd4) begin
            jp_len_hi = b;
            jp_pos    = jp_pos + 4'd1;
          end else if (jp_pos == 4'd5) begin
            jp_skip = {1'b0, jp_len_hi, b};
            jp_pos  = jp_pos + 4'd1;
          end else if (jp_pos > 4'd10 || b != JFIF_SIG[39 - 8*(jp_pos - 4'd6) -: 8]) begin
            decides = 1'b1;
            verdict = ST_NO_JFIF;
          end else if (jp_pos == 4'd10) begin
            // An APP0 length below seven would place the next marker inside the signature.
            if (jp_skip < 17'd7) begin
              decides = 1'b1;
              verdict = ST_CORRUPT;
            end else begin
              begin_skip(jp_skip - 17'd7);
            end
          end else begin
            jp_pos = jp_pos + 4'd1;
          end
        end
        PH_SKIP: begin
          if (jp_skip != 17'd0) jp_skip = jp_skip - 17'd1;
          if (jp_skip == 17'd0) begin
            jp_phase = PH_MARKER;
            jp_pos   = '0;
          end
        end
        PH_MARKER: begin
          if (jp_pos == 4'd0) begin
            if (b != MARKER_PREFIX) begin
              decides = 1'b1;
              verdict = ST_CORRUPT;
            end else begin
              jp_pos = 4'd1;
            end
          end else begin
            jp_phase = (b == MARKER_SOF0) ? PH_FRAME : PH_LENGTH;
            jp_pos   = '0;
          end
        end
        PH_LENGTH: begin
          if (jp_pos == 4'd0) begin
            jp_len_hi = b;
            jp_pos    = 4'd1;
          end else begin
            seg_len = {jp_len_hi, b};
            if (seg_len < 16'd2) begin
              decides = 1'b1;
              verdict = ST_CORRUPT;
            end else begin
              begin_skip({1'b0, seg_len} - 17'd2);
            end
          end
        end
        PH_FRAME: begin
          // Frame length and precision are passed over unchecked.
          if (jp_pos >= 4'd6) begin
            w       = {jp_width_hi, b};
            decides = 1'b1;
            verdict = ST_FOUND;
          end else begin
            if (jp_pos == 4'd3) jp_height = {b, 8'h00};
            else if (jp_pos == 4'd4) jp_height[7:0] = b;
            else if (jp_pos == 4'd5) jp_width_hi = b;
            jp_pos = jp_pos + 4'd1;
          end
        end
        default: begin
          decides = 1'b1;
          verdict = ST_CORRUPT;
        end
      endcase
    end
    if (decides) begin
      r.status = verdict;
      r.height = (verdict == ST_FOUND) ? jp_height : 16'h0;
      r.width  = (verdict == ST_FOUND) ? w : 16'h0;
      has      = 1'b1;
      jp_done  = 1'b1;
    end else if (last && !jp_done) begin
      r.status = ST_EARLY;
      has      = 1'b1;
    end
    if (last) begin
      jp_phase    = PH_HEADER;
      jp_pos      = '0;
      jp_skip     = '0;
      jp_len_hi   = '0;
      jp_height   = '0;
      jp_width_hi = '0;
      jp_done     = 1'b0;
    end
    return has;
  endfunction

  // Mostly back to back, sometimes a short gap, now and then a long one.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Builds one file into file_buf. Good files are a JFIF header, a few ordinary segments and
  // a frame header; the other kinds break one piece of that structure, noise files are random
  // bytes. A huge file declares the longest APP0 length and ends inside its body.
  function automatic void build_file(input file_kind_e kind);
    int          app_len, app_fill, nseg, bad_seg, miss_at, seg_len, cut, idx, i, k;
    logic [7:0]  code;
    logic [15:0] hgt, wid;
    file_buf.delete();
    if (kind == FILE_NOISE) begin
      repeat ($urandom_range(1, 16)) file_buf.push_back(any_byte());
      return;
    end
    for (k = 0; k < 4; k++) file_buf.push_back(START_SEQ[31 - 8*k -: 8]);
    if (kind == FILE_HUGE) app_len = 16'hFFFF;
    else if (kind == FILE_SHORT_APP0) app_len = $urandom_range(0, 6);
    else app_len = 7 + $urandom_range(0, 12);
    file_buf.push_back(8'(app_len >> 8));
    file_buf.push_back(8'(app_len));
    for (k = 0; k < 5; k++) file_buf.push_back(JFIF_SIG[39 - 8*k -: 8]);
    if (kind == FILE_HUGE) begin
      repeat ($urandom_range(1, 30)) file_buf.push_back(any_byte());
      return;
    end
    app_fill = (app_len >= 7) ? app_len - 7 : $urandom_range(0, 3);
    repeat (app_fill) file_buf.push_back(any_byte());

    if (kind == FILE_SHORT_SEG) nseg = $urandom_range(1, 3);
    else nseg = $urandom_range(0, 3);
    bad_seg = (kind == FILE_SHORT_SEG) ? $urandom_range(0, nseg - 1) : -1;
    miss_at = (kind == FILE_NO_MARKER) ? $urandom_range(0, nseg) : -1;

    for (i = 0; i <= nseg; i++) begin
      if (i == miss_at) file_buf.push_back(8'($urandom_range(0, 254)));
      else file_buf.push_back(MARKER_PREFIX);
      if (i < nseg) begin
        // A second marker byte of FF is an ordinary segment too.
        code = any_byte();
        if (code == MARKER_SOF0 || $urandom_range(0, 3) == 0) code = MARKER_PREFIX;
        file_buf.push_back(code);
        if (i == bad_seg) seg_len = $urandom_range(0, 1);
        else seg_len = 2 + $urandom_range(0, 10);
        file_buf.push_back(8'(seg_len >> 8));
        file_buf.push_back(8'(seg_len));
        repeat ((seg_len >= 2) ? seg_len - 2 : 2) file_buf.push_back(any_byte());
      end else begin
        file_buf.push_back(MARKER_SOF0);
        repeat (3) file_buf.push_back(any_byte());
        k   = $urandom_range(0, 9);
        hgt = (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        k   = $urandom_range(0, 9);
        wid = (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        file_buf.push_back(hgt[15:8]);
        file_buf.push_back(hgt[7:0]);
        file_buf.push_back(wid[15:8]);
        file_buf.push_back(wid[7:0]);
        repeat ($urandom_range(0, 4)) file_buf.push_back(any_byte());
      end
    end

    if (kind == FILE_GOOD && $urandom_range(0, 99) < 15) begin
      cut = $urandom_range(1, file_buf.size());
      while (file_buf.size() > cut) void'(file_buf.pop_back());
    end else if (kind == FILE_FLIPPED) begin
      idx = $urandom_range(0, file_buf.size() - 1);
      file_buf[idx] = any_byte();
    end
  endfunction

  // Offers one request, after a random gap unless burst is set, and returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                           input frame_result_t want, input bit burst);
    int gap;
    gap = burst ? 0 : idle_len();
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= last;
    cur_typed = typed;
    cur_want  = want;
    do @(posedge clk); while (!byte_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_file(input bit burst);
    int i;
    for (i = 0; i < file_buf.size(); i++)
      send_byte(file_buf[i], i == file_buf.size() - 1, 1'b0, '0, burst);
  endtask

  // Drops valid and holds the input side quiet until every report due has come out.
  task automatic drain_reports();
    byte_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_reports.size() != 0) @(negedge clk);
  endtask

  initial begin : byte_source
    int         i, sent, roll;
    bit         paused, huge_done;
    file_kind_e kind;
    stim_row_t  row;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = 8'h00;
    byte_ch.last_byte = 1'b0;
    cur_typed         = 1'b0;
    cur_want          = '0;

    directed_tbl = '{
      '{8'h00, 1'b1, 1'b1, ST_BAD_START, 16'h0000, 16'h0000},
      '{8'hFF, 1'b1, 1'b1, ST_EARLY,     16'h0000, 16'h0000},
      // Smallest good file: APP0 length seven, so the frame marker follows the signature.
      '{8'hFF, 1'b0, 1'b0, ST_FOUND, 16'h0, 16'h0},
      '{8'hD8, 1'b0, 1'b0, ST_FOUND, 16'h0, 16'h0},
      '{8'hFF, 1'b0, 1'b0, ST_FOUND, 16'h0, 16'h0},
      '{8'hE0, 1'b0, 1'b0, ST_FOUND, 16'h0, 16'h0},
      '{8'h00, 1'b0, 1'b0, ST_FOUND, 16'h0, 16'h0},
      '{8'h07, 1'b0, 1'b0, ST_FOUND, 16'h0, 16'h0},
      '{8'h4A, 1'b0, 1'b0, ST_FOUND, 16'h0, 16'h0},
      '{8'h46, 1'b0, 1'b0, ST_FOUND, 16'h0, 16'h0},
      '{8'h49, 1'b0, 1'b0, ST_FOUND, 16'h0, 16'h0},
      '{8'h46, 1'b0, 1'b0, ST_FOUND, 16'h0, 16'h0},
      '{8'h00, 1'b0, 1'b0, ST_FOUND, 16'h0, 16'h0},
      '{8'hFF, 1'b0, 1'b0, ST_FOUND, 16'h0, 16'h0},
      '{8'hC0, 1'b0, 1'b0, ST_FOUND, 16'h0, 16'h0},
      '{8'h00, 1'b0, 1'b0, ST_FOUND, 16'h0, 16'h0},
      '{8'h11, 1'b0, 1'b0, ST_FOUND, 16'h0, 16'h0},
      '{8'h08, 1'b0, 1'b0, ST_FOUND, 16'h0, 16'h0},
      '{8'hFF, 1'b0, 1'b0, ST_FOUND, 16'h0, 16'h0},
      '{8'hFF, 1'b0, 1'b0, ST_FOUND, 16'h0, 16'h0},
      '{8'h00, 1'b0, 1'b0, ST_FOUND, 16'h0, 16'h0},
      '{8'h00, 1'b1, 1'b1, ST_FOUND, 16'hFFFF, 16'h0000},
      '{8'hD8, 1'b1, 1'b1, ST_BAD_START, 16'h0000, 16'h0000},
      // A bad second byte that is also the last byte still reports the bad header.
      '{8'hFF, 1'b0, 1'b0, ST_FOUND, 16'h0, 16'h0},
      '{8'h00, 1'b1, 1'b1, ST_BAD_START, 16'h0000, 16'h0000}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_tbl[i];
      send_byte(row.data, row.last, row.typed, '{row.status, row.height, row.width}, 1'b0);
    end
    drain_reports();

    sent      = 0;
    paused    = 1'b0;
    huge_done = 1'b0;
    while (sent < RANDOM_BYTES) begin
      if (!huge_done && sent >= 900) begin
        // Longest APP0 length, sent without gaps; the file ends inside the APP0 body.
        build_file(FILE_HUGE);
        sent += file_buf.size();
        send_file(1'b1);
        huge_done = 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 58) kind = FILE_GOOD;
        else if (roll < 66) kind = FILE_SHORT_APP0;
        else if (roll < 74) kind = FILE_SHORT_SEG;
        else if (roll < 82) kind = FILE_NO_MARKER;
        else if (roll < 92) kind = FILE_FLIPPED;
        else kind = FILE_NOISE;
        build_file(kind);
        sent += file_buf.size();
        send_file(1'b0);
      end
      if (!paused && sent >= 500) begin
        paused = 1'b1;
        drain_reports();
      end
    end

    byte_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: random stalls, long runs of ready, and one long hold-off so that the
  // parser fills up and pushes back on the byte stream.
  initial begin : report_sink
    int wait_len, run_len;
    bit held_long;
    held_long     = 1'b0;
    size_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!held_long && reports_seen >= 12) begin
        held_long = 1'b1;
        size_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      wait_len = idle_len();
      if (wait_len > 0) begin
        size_ch.ready <= 1'b0;
        repeat (wait_len) @(negedge clk);
      end
      size_ch.ready <= 1'b1;
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
      repeat (run_len) @(negedge clk);
    end
  end

  // Reports are checked before the request of the same edge is predicted.
  always @(posedge clk) begin
    frame_result_t got, want, pred;
    bit            has_pred;
    if (rst_n) begin
      if (size_ch.valid && size_ch.ready) begin
        got = '{size_ch.status, size_ch.image_height, size_ch.image_width};
        reports_seen++;
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected report, expected none, got status %0d", $time, got.status);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, got.status);
            mismatches++;
          end
          if (got.height !== want.height) begin
            $display("%0t: image_height mismatch, expected %0d, got %0d",
                     $time, want.height, got.height);
            mismatches++;
          end
          if (got.width !== want.width) begin
            $display("%0t: image_width mismatch, expected %0d, got %0d",
                     $time, want.width, got.width);
            mismatches++;
          end
        end
      end
      if (byte_ch.valid && byte_ch.ready) begin
        has_pred = parse_jpeg_byte(byte_ch.data_byte, byte_ch.last_byte, pred);
        if (cur_typed) pending_reports.push_back(cur_want);
        else if (has_pred) pending_reports.push_back(pred);
      end
    end
  end

  initial begin : watchdog
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[jpeg_frame_size_parser.f]
+incdir+rtl
rtl/jfsp_pkg.sv
rtl/jfsp_intf.sv
rtl/jfsp_step.sv
rtl/jpeg_frame_size_parser.sv
sim/tb_jpeg_frame_size_parser.sv
